// ===== src/wpc_pkg.sv =====
`timescale 1ns / 1ps
package wpc_pkg;
    localparam int MaxWaypoints = 64;
    localparam int AddrW        = $clog2(MaxWaypoints);
    localparam int IdxW         = AddrW + 1;
    localparam int CordicIters  = 16;
    localparam int IterW        = $clog2(CordicIters + 1);
    localparam int CW           = 40;

    localparam logic signed [CW-1:0] PiQ29     = 40'sd1686629713;
    localparam logic signed [CW-1:0] TwoPiQ29  = 40'sd3373259426;
    localparam logic signed [CW-1:0] HalfPiQ29 = 40'sd843314857;
    localparam logic [29:0]          GainInvQ30 = 30'd652032875;

    typedef enum logic [2:0] {
        REG_LINEAR_GAIN = 3'd0,
        REG_YAW_GAIN    = 3'd1,
        REG_SPEED_LIMIT = 3'd2,
        REG_YAW_LIMIT   = 3'd3,
        REG_POS_TOL     = 3'd4,
        REG_HEAD_TOL    = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_TARGET, S_QUAT, S_YAW, S_ERR, S_MUL, S_FINISH, S_OUT
    } t_state;

    typedef struct packed {
        logic load_inputs;
        logic start_target;
        logic start_yaw;
        logic calc_err;
        logic calc_mul;
        logic calc_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_busy;
        logic yaw_needed;
    } t_dp_status;

    function automatic logic signed [CW-1:0] atan_step(input logic [IterW-1:0] i);
        logic signed [CW-1:0] r;
        r = '0;
        case (i)
            0: r = 40'sd421657428;
            1: r = 40'sd248918915;
            2: r = 40'sd131521918;
            3: r = 40'sd66762579;
            4: r = 40'sd33510843;
            5: r = 40'sd16771758;
            6: r = 40'sd8387925;
            7: r = 40'sd4194219;
            8: r = 40'sd2097141;
            9: r = 40'sd1048575;
            default: r = (i <= 29) ? (40'sd1 <<< (29 - i)) : '0;
        endcase
        return r;
    endfunction
endpackage

// ===== src/wpc_ram.sv =====
`timescale 1ns / 1ps
module wpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== src/wpc_cordic.sv =====
`timescale 1ns / 1ps
module wpc_cordic
    import wpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_busy,
    output logic signed [CW-1:0] o_angle,
    output logic signed [CW-1:0] o_mag
);
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [IterW-1:0]     r_iter;
    logic                 r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_iter <= '0;
            if (i_x == 0 && i_y == 0) begin
                r_busy <= 1'b0;
                r_x <= '0; r_y <= '0; r_z <= '0;
            end else begin
                r_busy <= 1'b1;
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        r_x <= i_y; r_y <= -i_x; r_z <= HalfPiQ29;
                    end else begin
                        r_x <= -i_y; r_y <= i_x; r_z <= -HalfPiQ29;
                    end
                end else begin
                    r_x <= i_x; r_y <= i_y; r_z <= '0;
                end
            end
        end else if (r_busy) begin
            // one micro-rotation a cycle
            if (r_y >= 0) begin
                r_x <= r_x + (r_y >>> r_iter);
                r_y <= r_y - (r_x >>> r_iter);
                r_z <= r_z + atan_step(r_iter);
            end else begin
                r_x <= r_x - (r_y >>> r_iter);
                r_y <= r_y + (r_x >>> r_iter);
                r_z <= r_z - atan_step(r_iter);
            end
            r_iter <= r_iter + 1'b1;
            if (r_iter == IterW'(CordicIters - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_z;
    assign o_mag   = r_x;
endmodule

// ===== src/wpc_datapath.sv =====
`timescale 1ns / 1ps
module wpc_datapath
    import wpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wpc_pkg::t_dp_cmd    i_cmd,
    output wpc_pkg::t_dp_status o_status,
    input  logic [31:0]         i_wp_x,
    input  logic [31:0]         i_wp_y,
    input  logic [31:0]         i_wp_z,
    input  logic [31:0]         i_pos_x,
    input  logic [31:0]         i_pos_y,
    input  logic [31:0]         i_pos_z,
    input  logic [15:0]         i_quat_x,
    input  logic [15:0]         i_quat_y,
    input  logic [15:0]         i_quat_z,
    input  logic [15:0]         i_quat_w,
    input  logic [15:0]         i_linear_gain,
    input  logic [15:0]         i_yaw_gain,
    input  logic [30:0]         i_speed_limit,
    input  logic [30:0]         i_yaw_limit,
    input  logic [30:0]         i_pos_tol,
    input  logic [30:0]         i_head_tol,
    output logic [31:0]         o_forward,
    output logic [31:0]         o_vertical,
    output logic [31:0]         o_yaw_rate,
    output logic                o_advance
);
    logic signed [CW-1:0] r_dx, r_dy, r_dz, r_target, r_dist, r_yaw, r_err;
    logic signed [16:0]   r_qx, r_qy, r_qz, r_qw;
    logic signed [CW-1:0] r_qa, r_qb;
    logic                 r_yaw_ok, r_yaw_needed;
    logic signed [63:0]   r_pf, r_pv, r_py;
    logic [31:0]          r_fwd, r_vert, r_yrate;
    logic                 r_adv;

    logic                 cord_start;
    logic signed [CW-1:0] cord_x, cord_y, cord_ang, cord_mag;
    logic                 cord_busy;

    logic signed [35:0]   xx, yy, zz, ww, xy, wz, xz, wy;
    logic signed [37:0]   norm, m20, m20a;
    logic signed [CW-1:0] e0, e1;
    logic [63:0]          dmul;

    assign cord_start = i_cmd.start_target | i_cmd.start_yaw;
    assign cord_x     = i_cmd.start_target ? r_dx : r_qa;
    assign cord_y     = i_cmd.start_target ? r_dy : r_qb;

    wpc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (cord_x),
        .i_y     (cord_y),
        .o_busy  (cord_busy),
        .o_angle (cord_ang),
        .o_mag   (cord_mag)
    );

    always_comb begin
        xx = r_qx * r_qx; yy = r_qy * r_qy; zz = r_qz * r_qz; ww = r_qw * r_qw;
        xy = r_qx * r_qy; wz = r_qw * r_qz; xz = r_qx * r_qz; wy = r_qw * r_qy;
        norm = 38'(xx) + 38'(yy) + 38'(zz) + 38'(ww);
        m20  = (38'(xz) - 38'(wy)) <<< 1;
        m20a = (m20 < 0) ? -m20 : m20;
        // wrap once each way; the raw difference spans under three turns
        e0 = r_target - r_yaw;
        if (e0 >= PiQ29) begin
            e1 = e0 - TwoPiQ29;
        end else if (e0 < -PiQ29) begin
            e1 = e0 + TwoPiQ29;
        end else begin
            e1 = e0;
        end
        dmul = 64'(cord_mag[33:0]) * 64'(GainInvQ30);
    end

    function automatic logic [31:0] clamp_rnd(input logic signed [63:0] p,
                                               input int unsigned sh,
                                               input logic [30:0] lim);
        logic signed [63:0] v, l;
        v = (p + (64'sd1 <<< (sh - 1))) >>> sh;
        l = 64'(lim);
        if (v > l) v = l;
        else if (v < -l) v = -l;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_inputs) begin
            r_dx <= CW'($signed(i_wp_x)) - CW'($signed(i_pos_x));
            r_dy <= CW'($signed(i_wp_y)) - CW'($signed(i_pos_y));
            r_dz <= CW'($signed(i_wp_z)) - CW'($signed(i_pos_z));
            r_qx <= 17'($signed(i_quat_x)); r_qy <= 17'($signed(i_quat_y));
            r_qz <= 17'($signed(i_quat_z)); r_qw <= 17'($signed(i_quat_w));
        end
        if (i_cmd.start_target) begin
            r_qa <= CW'(ww) + CW'(xx) - CW'(yy) - CW'(zz);
            r_qb <= (CW'(xy) + CW'(wz)) <<< 1;
            r_yaw_ok <= (norm != 0);
            r_yaw_needed <= (norm != 0) && (m20a < norm);
            r_yaw <= '0;
        end
        if (i_cmd.start_yaw) begin
            // cordic holds the target result until restarted
            r_target <= cord_ang;
            r_dist <= CW'((dmul + 64'd536870912) >> 30);
        end
        if (i_cmd.calc_err) begin
            if (r_yaw_needed) r_yaw <= cord_ang;
        end
        if (i_cmd.calc_mul) begin
            r_err <= r_yaw_ok ? e1 : '0;
            r_pf <= $signed({1'b0, i_linear_gain}) * r_dist;
            r_pv <= $signed({1'b0, i_linear_gain}) * r_dz;
            r_py <= $signed({1'b0, i_yaw_gain}) * (r_yaw_ok ? e1 : 40'sd0);
        end
        if (i_cmd.calc_finish) begin
            r_fwd   <= clamp_rnd(r_pf, 8, i_speed_limit);
            r_vert  <= clamp_rnd(r_pv, 8, i_speed_limit);
            r_yrate <= r_yaw_ok ? clamp_rnd(r_py, 21, i_yaw_limit) : 32'd0;
            r_adv   <= r_yaw_ok && (r_dist < CW'(i_pos_tol))
                       && (44'((r_err < 0) ? -r_err : r_err) < {i_head_tol, 13'd0})
                       && (((r_dz < 0) ? -r_dz : r_dz) < CW'(i_pos_tol));
        end
    end

    assign o_status.cordic_busy = cord_busy;
    assign o_status.yaw_needed  = r_yaw_needed;
    assign o_forward  = r_fwd;
    assign o_vertical = r_vert;
    assign o_yaw_rate = r_yrate;
    assign o_advance  = r_adv;
endmodule

// ===== src/wpc_controller.sv =====
`timescale 1ns / 1ps
module wpc_controller
    import wpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_out_ready,
    input  wpc_pkg::t_dp_status i_status,
    output wpc_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_step_done,
    output logic                o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_READ;
            S_READ:   n_state = S_TARGET;
            S_TARGET: n_state = S_QUAT;
            S_QUAT:   if (!i_status.cordic_busy) n_state = S_YAW;
            S_YAW:    n_state = S_ERR;
            S_ERR:    if (!i_status.cordic_busy || !i_status.yaw_needed) n_state = S_MUL;
            S_MUL:    n_state = S_FINISH;
            S_FINISH: n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        o_step_done = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE:   o_busy = 1'b0;
            S_READ:   o_cmd.load_inputs = 1'b1;
            S_TARGET: o_cmd.start_target = 1'b1;
            S_QUAT:   ;
            S_YAW:    if (i_status.yaw_needed) o_cmd.start_yaw = 1'b1;
                      else o_cmd.start_yaw = 1'b1;
            S_ERR:    if (!i_status.cordic_busy || !i_status.yaw_needed) o_cmd.calc_err = 1'b1;
            S_MUL:    o_cmd.calc_mul = 1'b1;
            S_FINISH: begin
                o_cmd.calc_finish = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_step_done = i_out_ready;
            end
            default:  ;
        endcase
    end
endmodule

// ===== src/waypoint_p_controller.sv =====
`timescale 1ns / 1ps
// Proportional waypoint follower.
// Slave stream: one beat is a load (tuser operation=0) or a control tick
// (operation=1). Loads write the waypoint table and give no beat
// out. Ticks measure planar distance and bearing to the current waypoint with
// an iterative CORDIC, take yaw from the quaternion with a second pass of the
// same CORDIC, wrap the yaw error and issue clamped proportional commands.
// Master stream: one beat per tick carrying the commands and index status.
// Flow: a full tick runs two passes of the shared 16-step CORDIC between the
// read, target, yaw, error, multiply and finish states. The wait on the second
// pass is skipped when no yaw is needed, and the first pass ends at once when
// the planar offset is zero. The next beat is taken in the cycle after the
// result leaves.
// Forced-off ticks answer in the next cycle; s_tready stays low until it leaves.
// Configuration: i_cfg_we writes register i_cfg_addr on any clock edge.
// Reset: synchronous, active low; clears index, count and control state,
// loads default gains, limits and tolerances. The table is undefined.
// Stall: a result beat waits in the output register while m_tready is low;
// no new beat is taken until it leaves.
module waypoint_p_controller
    import wpc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], quat_x, quat_y, quat_z,
    // quat_w (16 each, [159:96])
    input  logic [159:0] s_tdata,
    // tuser: operation[0], list_start[1], pose_valid[2], source_present[3]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: forward_speed[31:0], vertical_speed[63:32], yaw_rate[95:64],
    // target_index[102:96], zero fill to 104 bits
    output logic [103:0] m_tdata,
    // tuser: arrived[0], finished[1], command_active[2]
    output logic [2:0]   m_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [30:0]  i_cfg_data
);
    logic [15:0] r_lin_gain, r_yaw_gain;
    logic [30:0] r_speed_lim, r_yaw_lim, r_pos_tol, r_head_tol;
    logic [IdxW-1:0] r_index, r_count;
    logic [IdxW-1:0] n_index, n_count;

    logic [31:0] r_px, r_py, r_pz;
    logic [15:0] r_qx, r_qy, r_qz, r_qw;

    // quick path register for forced-off ticks
    logic        r_off_valid;
    logic        busy, step_done, dp_valid;
    t_dp_cmd     cmd;
    t_dp_status  status;
    logic [31:0] fwd, vert, yrate;
    logic        advance;
    logic [31:0] wx, wy, wz;

    logic accept, is_load, active_ok, wr_en;
    logic [AddrW-1:0] wr_addr;

    assign s_tready = !busy && !r_off_valid;
    assign accept   = s_tvalid && s_tready;
    assign is_load  = !s_tuser[0];
    assign active_ok = s_tuser[2] && s_tuser[3] && (r_index < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain  <= 16'd205;
            r_yaw_gain  <= 16'd384;
            r_speed_lim <= 31'd65536;
            r_yaw_lim   <= 31'd65536;
            r_pos_tol   <= 31'd9830;
            r_head_tol  <= 31'd13107;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_LINEAR_GAIN: r_lin_gain  <= i_cfg_data[15:0];
                REG_YAW_GAIN:    r_yaw_gain  <= i_cfg_data[15:0];
                REG_SPEED_LIMIT: r_speed_lim <= i_cfg_data;
                REG_YAW_LIMIT:   r_yaw_lim   <= i_cfg_data;
                REG_POS_TOL:     r_pos_tol   <= i_cfg_data;
                REG_HEAD_TOL:    r_head_tol  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // load bookkeeping: list start clears, full table drops the beat
    always_comb begin
        n_index = r_index;
        n_count = r_count;
        wr_en   = 1'b0;
        if (accept && is_load) begin
            if (s_tuser[1]) begin
                n_index = '0;
                n_count = '0;
            end
            if (n_count < IdxW'(MaxWaypoints)) begin
                wr_en   = 1'b1;
                n_count = n_count + 1'b1;
            end
        end
        if (step_done && advance) n_index = r_index + 1'b1;
    end
    assign wr_addr = s_tuser[1] ? '0 : r_count[AddrW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_count     <= '0;
            r_off_valid <= 1'b0;
        end else begin
            r_index <= n_index;
            r_count <= n_count;
            if (accept && !is_load && !active_ok) r_off_valid <= 1'b1;
            else if (r_off_valid && m_tready)     r_off_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= s_tdata[31:0];   r_py <= s_tdata[63:32];  r_pz <= s_tdata[95:64];
            r_qx <= s_tdata[111:96]; r_qy <= s_tdata[127:112];
            r_qz <= s_tdata[143:128]; r_qw <= s_tdata[159:144];
        end
    end

    wpc_ram #(.WIDTH(32), .DEPTH(MaxWaypoints)) u_ram_x (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_addr), .i_wdata(s_tdata[31:0]),
        .i_raddr(r_index[AddrW-1:0]), .o_rdata(wx));
    wpc_ram #(.WIDTH(32), .DEPTH(MaxWaypoints)) u_ram_y (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_addr), .i_wdata(s_tdata[63:32]),
        .i_raddr(r_index[AddrW-1:0]), .o_rdata(wy));
    wpc_ram #(.WIDTH(32), .DEPTH(MaxWaypoints)) u_ram_z (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_addr), .i_wdata(s_tdata[95:64]),
        .i_raddr(r_index[AddrW-1:0]), .o_rdata(wz));

    wpc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && !is_load && active_ok),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_step_done (step_done),
        .o_out_valid (dp_valid)
    );

    wpc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_wp_x(wx), .i_wp_y(wy), .i_wp_z(wz),
        .i_pos_x(r_px), .i_pos_y(r_py), .i_pos_z(r_pz),
        .i_quat_x(r_qx), .i_quat_y(r_qy), .i_quat_z(r_qz), .i_quat_w(r_qw),
        .i_linear_gain(r_lin_gain), .i_yaw_gain(r_yaw_gain),
        .i_speed_limit(r_speed_lim), .i_yaw_limit(r_yaw_lim),
        .i_pos_tol(r_pos_tol), .i_head_tol(r_head_tol),
        .o_forward(fwd), .o_vertical(vert), .o_yaw_rate(yrate), .o_advance(advance)
    );

    // the index shown is the one after the tick
    logic [IdxW-1:0] shown_index;
    assign shown_index = (dp_valid && advance) ? r_index + 1'b1 : r_index;

    assign m_tvalid = dp_valid || r_off_valid;
    assign m_tdata  = dp_valid ? {1'b0, 7'(shown_index), yrate, vert, fwd}
                               : {1'b0, 7'(r_index), 96'd0};
    assign m_tuser  = {dp_valid, (shown_index >= r_count), dp_valid && advance};
endmodule
